[hdl/bde_pkg.sv]
package bde_pkg;

  // Default sizing
  localparam int MAX_DEGREE = 3;
  localparam int MAX_POINTS = 64;
  localparam int FRAC_BITS  = 16;

  // Input item kinds
  localparam logic [1:0] KIND_CTRL = 2'd0;
  localparam logic [1:0] KIND_KNOT = 2'd1;
  localparam logic [1:0] KIND_EVAL = 2'd2;

  // Configuration register indexes
  localparam logic CFG_DEGREE = 1'b0;
  localparam logic CFG_KNOTS  = 1'b1;

  // Register reset values
  localparam logic [1:0] DEGREE_RESET = 2'd3;
  localparam logic [6:0] KNOTS_RESET  = 7'd8;

  // Largest blend ratio magnitude
  localparam logic [31:0] RATIO_LIM = 32'h7FFF_FFFF;

endpackage

[hdl/bde_mem.sv]
module bde_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/bde_div.sv]
module bde_div #(
  parameter int FRAC_BITS = bde_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] num_base,
  input  logic signed [32:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  localparam int NW = 33 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] qn;
  logic [32:0]   dmag;
  logic [32:0]   rem;
  logic          neg;
  logic [32:0]   nabs;
  logic [33:0]   trial;
  logic          fits;
  logic [31:0]   qmag;

  assign nabs  = num_base[32] ? 33'(-num_base) : 33'(num_base);
  assign trial = {rem, qn[NW-1]};

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qn   <= {nabs, {FRAC_BITS{1'b0}}};
      dmag <= den[32] ? 33'(-den) : 33'(den);
      rem  <= '0;
      neg  <= num_base[32] ^ den[32];
    end else if (busy) begin
      if (trial >= {1'b0, dmag}) begin
        rem <= 33'(trial - {1'b0, dmag});
        qn  <= {qn[NW-2:0], 1'b1};
      end else begin
        rem <= trial[32:0];
        qn  <= {qn[NW-2:0], 1'b0};
      end
    end
  end

  // Saturate magnitude, then apply sign
  assign fits = (qn[NW-1:31] == '0);
  assign qmag = fits ? {1'b0, qn[30:0]} : bde_pkg::RATIO_LIM;
  assign quo  = neg ? $signed(-qmag) : $signed(qmag);

endmodule

[hdl/bde_seq.sv]
module bde_seq #(
  parameter int MAX_DEGREE = bde_pkg::MAX_DEGREE,
  parameter int FRAC_BITS  = bde_pkg::FRAC_BITS,
  parameter int CTRL_DEPTH = 64,
  parameter int KNOT_DEPTH = 68,
  parameter int CAW        = 6,
  parameter int KAW        = 7,
  parameter int IDXW       = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] t_in,
  input  logic [1:0]         curve_degree,
  input  logic [6:0]         knot_count,
  output logic               busy,
  output logic               ctrl_re,
  output logic [CAW-1:0]     ctrl_raddr,
  input  logic [31:0]        ctrl_rdata,
  output logic               knot_re,
  output logic [KAW-1:0]     knot_raddr,
  input  logic [31:0]        knot_rdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] curve_value
);

  localparam int DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE + 1) : 1;
  localparam int KW = $clog2(MAX_DEGREE + 2);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_LRD   = 4'd3;
  localparam logic [3:0] S_LWR   = 4'd4;
  localparam logic [3:0] S_KLO   = 4'd5;
  localparam logic [3:0] S_KHI   = 4'd6;
  localparam logic [3:0] S_KCAP  = 4'd7;
  localparam logic [3:0] S_DIVGO = 4'd8;
  localparam logic [3:0] S_DIVW  = 4'd9;
  localparam logic [3:0] S_MUL   = 4'd10;
  localparam logic [3:0] S_BLEND = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]             state;
  logic signed [31:0]     t;
  logic [DW-1:0]          deg;
  logic signed [IDXW-1:0] ok;
  logic signed [IDXW-1:0] ng;
  logic signed [IDXW-1:0] mid;
  logic signed [IDXW-1:0] lidx;
  logic signed [IDXW-1:0] i;
  logic [KW-1:0]          k;
  logic [KW-1:0]          j;
  logic                   oob;
  logic signed [31:0]     win [MAX_DEGREE + 1];
  logic signed [31:0]     prev;
  logic signed [31:0]     cur;
  logic signed [31:0]     lo;
  logic signed [31:0]     hi;
  logic signed [32:0]     diff;
  logic signed [31:0]     a;
  logic signed [64:0]     prod;

  // Divider hookup
  logic                   div_start;
  logic                   div_done;
  logic signed [31:0]     div_quo;
  logic signed [32:0]     num_base;
  logic signed [32:0]     den;

  assign num_base = 33'(t) - 33'(lo);
  assign den      = 33'(hi) - 33'(lo);
  assign div_start = (state == S_DIVGO) && (hi != lo);

  bde_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num_base (num_base),
    .den      (den),
    .done     (div_done),
    .quo      (div_quo)
  );

  // Degree clamp and search bounds
  logic [DW-1:0]          dsel;
  logic signed [IDXW-1:0] gap;
  logic signed [IDXW:0]   msum;
  logic signed [IDXW:0]   mtrunc;
  logic signed [IDXW-1:0] base;
  logic signed [IDXW-1:0] w_full;
  logic [DW-1:0]          w;
  logic signed [IDXW-1:0] cidx;
  logic signed [IDXW-1:0] kidx;
  logic                   cin;
  logic                   kin;
  logic signed [31:0]     kval;
  logic signed [31:0]     cval;
  logic                   res_load;
  logic                   row_end;

  assign dsel   = (32'(curve_degree) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(curve_degree);
  assign gap    = ng - ok;
  assign msum   = (IDXW + 1)'(ok) + (IDXW + 1)'(ng);
  assign mtrunc = msum[IDXW] ? ((msum + 2'sd1) >>> 1) : (msum >>> 1);
  assign base   = lidx - IDXW'(deg);
  assign w_full = i - base;
  assign w      = w_full[DW-1:0];

  // Last window entry of the current recursion level
  assign row_end = (i - 2'sd1) < (base + $signed(IDXW'(k)));

  // Table addressing
  always_comb begin
    cidx = base + IDXW'(j);
    case (state)
      S_KLO:   kidx = i;
      S_KHI:   kidx = i + IDXW'(deg) + IDXW'(1) - IDXW'(k);
      default: kidx = mtrunc[IDXW-1:0];
    endcase
  end

  assign cin  = !cidx[IDXW-1] && ($unsigned(cidx) < IDXW'(CTRL_DEPTH));
  assign kin  = !kidx[IDXW-1] && ($unsigned(kidx) < IDXW'(KNOT_DEPTH));
  assign ctrl_raddr = cidx[CAW-1:0];
  assign knot_raddr = kidx[KAW-1:0];
  assign ctrl_re = (state == S_LRD) && cin;
  assign knot_re = kin && ((state == S_KLO) || (state == S_KHI) ||
                           ((state == S_SRCH) && (gap > 1 || gap < -1)));
  assign kval = oob ? 32'sd0 : $signed(knot_rdata);
  assign cval = oob ? 32'sd0 : $signed(ctrl_rdata);
  assign busy = (state != S_IDLE);

  // Result register free to take the finished value
  assign res_load = (state == S_DONE) && (!out_valid || !out_stall);

  // Blend: prev + floor(a*diff / 2^F), saturated
  logic signed [64:0] sh;
  logic signed [65:0] bsum;
  logic signed [31:0] bsat;

  assign sh   = prod >>> FRAC_BITS;
  assign bsum = 66'(sh) + 66'(prev);
  always_comb begin
    if (bsum[65:31] == '0 || bsum[65:31] == '1) begin
      bsat = bsum[31:0];
    end else if (bsum[65]) begin
      bsat = 32'sh8000_0000;
    end else begin
      bsat = 32'sh7FFF_FFFF;
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (gap > 1 || gap < -1) begin
            state <= S_CMP;
          end else begin
            state <= S_LRD;
          end
        end
        S_CMP:  state <= S_SRCH;
        S_LRD:  state <= S_LWR;
        S_LWR: begin
          if (j == KW'(deg)) begin
            state <= (deg == '0) ? S_DONE : S_KLO;
          end else begin
            state <= S_LRD;
          end
        end
        S_KLO:   state <= S_KHI;
        S_KHI:   state <= S_KCAP;
        S_KCAP:  state <= S_DIVGO;
        S_DIVGO: state <= (hi == lo) ? S_MUL : S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_BLEND;
        S_BLEND: begin
          if (row_end && k == KW'(deg)) begin
            state <= S_DONE;
          end else begin
            state <= S_KLO;
          end
        end
        S_DONE: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        t   <= t_in;
        deg <= dsel;
        ok  <= IDXW'(dsel);
        ng  <= IDXW'(knot_count) - IDXW'(dsel);
      end
      S_SRCH: begin
        mid  <= mtrunc[IDXW-1:0];
        oob  <= !kin;
        lidx <= ok;
        j    <= '0;
      end
      S_CMP: begin
        if (kval <= t) begin
          ok <= mid;
        end else begin
          ng <= mid;
        end
      end
      S_LRD: oob <= !cin;
      S_LWR: begin
        win[j[DW-1:0]] <= cval;
        j <= j + 1'b1;
        k <= KW'(1);
        i <= lidx;
      end
      S_KLO: begin
        oob  <= !kin;
        prev <= win[DW'(w - 1'b1)];
      end
      S_KHI: begin
        lo  <= kval;
        oob <= !kin;
        cur <= win[w];
      end
      S_KCAP: hi <= kval;
      S_DIVGO: begin
        diff <= 33'(cur) - 33'(prev);
        a    <= 32'sd0;
      end
      S_DIVW: begin
        if (div_done) begin
          a <= div_quo;
        end
      end
      S_MUL: prod <= $signed({{33{a[31]}}, a}) * $signed({{32{diff[32]}}, diff});
      S_BLEND: begin
        win[w] <= bsat;
        if (row_end) begin
          k <= k + 1'b1;
          i <= lidx;
        end else begin
          i <= i - 2'sd1;
        end
      end
      S_DONE: begin
        if (res_load) begin
          curve_value <= win[deg];
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start && busy |-> 1'b0) else $error("evaluate started while busy");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIVW) else $error("divider finished outside wait");
  a_blend_win: assert property (@(posedge clk) disable iff (rst)
    state == S_KLO |-> w != '0) else $error("blend at window entry zero");
  a_result: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !(out_valid && out_stall) |=> out_valid)
    else $error("finished result not presented");

endmodule

[hdl/bspline_de_boor_evaluator_top.sv]
// Control point and knot writes are taken one per cycle, back to back, while not stalled.
// Evaluate: a binary search for the knot span, reads of the degree+1 window points, then
// degree*(degree+1)/2 blends on the 49-step shared divider (not on a flat span), then the
// result register load.
// Input stalls while busy or while a finished result waits. Sync active-high reset:
// degree 3, knot_count 8, no result pending; control point and knot tables are not cleared.
module bspline_de_boor_evaluator_top #(
  parameter int MAX_DEGREE = bde_pkg::MAX_DEGREE,
  parameter int MAX_POINTS = bde_pkg::MAX_POINTS,
  parameter int FRAC_BITS  = bde_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [6:0]         slot,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] curve_value,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data
);

  localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;
  localparam int CAW  = $clog2(MAX_POINTS);
  localparam int KAW  = $clog2(KNOT_DEPTH);
  localparam int IDXW = ((KAW > 7) ? KAW : 7) + 2;

  logic [1:0] curve_degree;
  logic [6:0] knot_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_degree <= bde_pkg::DEGREE_RESET;
      knot_count   <= bde_pkg::KNOTS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bde_pkg::CFG_DEGREE: curve_degree <= cfg_data[1:0];
        bde_pkg::CFG_KNOTS:  knot_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input transaction decode
  logic busy;
  logic accept;
  logic ctrl_we;
  logic knot_we;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign ctrl_we  = accept && (kind == bde_pkg::KIND_CTRL) && (32'(slot) < MAX_POINTS);
  assign knot_we  = accept && (kind == bde_pkg::KIND_KNOT) && (32'(slot) < KNOT_DEPTH);

  logic           ctrl_re;
  logic [CAW-1:0] ctrl_raddr;
  logic [31:0]    ctrl_rdata;
  logic           knot_re;
  logic [KAW-1:0] knot_raddr;
  logic [31:0]    knot_rdata;

  bde_mem #(.DEPTH(MAX_POINTS), .AW(CAW)) u_ctrl (
    .clk   (clk),
    .we    (ctrl_we),
    .waddr (CAW'(slot)),
    .wdata (value),
    .re    (ctrl_re),
    .raddr (ctrl_raddr),
    .rdata (ctrl_rdata)
  );

  bde_mem #(.DEPTH(KNOT_DEPTH), .AW(KAW)) u_knot (
    .clk   (clk),
    .we    (knot_we),
    .waddr (KAW'(slot)),
    .wdata (value),
    .re    (knot_re),
    .raddr (knot_raddr),
    .rdata (knot_rdata)
  );

  bde_seq #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS),
    .CTRL_DEPTH (MAX_POINTS),
    .KNOT_DEPTH (KNOT_DEPTH),
    .CAW        (CAW),
    .KAW        (KAW),
    .IDXW       (IDXW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (accept && (kind == bde_pkg::KIND_EVAL)),
    .t_in         (value),
    .curve_degree (curve_degree),
    .knot_count   (knot_count),
    .busy         (busy),
    .ctrl_re      (ctrl_re),
    .ctrl_raddr   (ctrl_raddr),
    .ctrl_rdata   (ctrl_rdata),
    .knot_re      (knot_re),
    .knot_raddr   (knot_raddr),
    .knot_rdata   (knot_rdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .curve_value  (curve_value)
  );

endmodule
